/* rtl/core/mtee_pkg.sv */
// Shared types and constants for the MIDI track event encoder.
package mtee_pkg;

   localparam int IDX_W = 3;

   localparam logic [1:0] KIND_NOTE  = 2'd0;
   localparam logic [1:0] KIND_TEMPO = 2'd1;
   localparam logic [1:0] KIND_EOT   = 2'd2;

   localparam logic [7:0] BYTE_ZERO      = 8'h00;
   localparam logic [7:0] VLQ_CONT       = 8'h80;
   localparam logic [7:0] STATUS_NOTE_ON = 8'h90;
   localparam logic [7:0] META_PREFIX    = 8'hFF;
   localparam logic [7:0] META_TEMPO     = 8'h51;
   localparam logic [7:0] META_TEMPO_LEN = 8'h03;
   localparam logic [7:0] META_EOT       = 8'h2F;

   localparam int          USPQ_NUM_W   = 26;
   localparam logic [25:0] USPQ_NUM     = 26'd60000000;
   localparam logic [23:0] USPQ_DEFAULT = 24'd500000;

   localparam logic [IDX_W-1:0] TEMPO_LAST_IDX = 3'd6;
   localparam logic [IDX_W-1:0] EOT_LAST_IDX   = 3'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic div_start;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic div_done;
      logic last;
   } stat_type;

endpackage

/* rtl/core/mtee_div.sv */
// Bit-serial restoring divider for the tempo value: 60000000 / bpm.
module mtee_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [9:0]  divisor,
   output logic        done,
   output logic [25:0] quotient
);
   import mtee_pkg::*;

   localparam int CNT_W = $clog2(USPQ_NUM_W);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [USPQ_NUM_W-1:0] num_ff, num_in;
   logic [USPQ_NUM_W-1:0] quo_ff, quo_in;
   logic [9:0]            rem_ff, rem_in;
   logic [9:0]            div_ff, div_in;
   logic [10:0]           rem_sh;
   logic [10:0]           rem_sub;
   logic                  ge;

   always_comb begin
      rem_sh  = {rem_ff, num_ff[USPQ_NUM_W-1]};
      rem_sub = rem_sh - {1'b0, div_ff};
      ge      = (rem_sh >= {1'b0, div_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = USPQ_NUM;
         quo_in  = '0;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? rem_sub[9:0] : rem_sh[9:0];
         quo_in = {quo_ff[USPQ_NUM_W-2:0], ge};
         num_in = {num_ff[USPQ_NUM_W-2:0], 1'b0};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(USPQ_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* rtl/core/mtee_dp.sv */
// Datapath: tick and byte count state, delta and VLQ, byte select, output register.
module mtee_dp #(
   parameter int VLQ_MAX_BYTES = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  mtee_pkg::cmd_type cmd,
   output mtee_pkg::stat_type stat,
   input  logic [1:0]        req_kind,
   input  logic [31:0]       event_tick,
   input  logic              note_on,
   input  logic [6:0]        note_number,
   input  logic [6:0]        velocity,
   input  logic [9:0]        bpm,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_byte,
   output logic              rsp_tlast,
   output logic [31:0]       rsp_length
);
   import mtee_pkg::*;

   localparam int CAP_W = 7 * VLQ_MAX_BYTES;
   localparam int EXT_W = 35;
   localparam logic [EXT_W-1:0] CAP = (EXT_W'(1) << CAP_W) - EXT_W'(1);

   logic [31:0]      tick_ff, tick_in;
   logic [31:0]      count_ff, count_in;
   logic [31:0]      delta_ff, delta_in;
   logic [1:0]       kind_ff, kind_in;
   logic             on_ff, on_in;
   logic [6:0]       note_ff, note_in;
   logic [6:0]       vel_ff, vel_in;
   logic             bpm_zero_ff, bpm_zero_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             vld_ff, vld_in;
   logic [7:0]       byte_ff, byte_in;
   logic             last_ff, last_in;
   logic [31:0]      len_ff, len_in;

   logic [31:0]      diff;
   logic [31:0]      delta_sat;
   logic [EXT_W-1:0] delta_ext;
   logic [IDX_W-1:0] vhi;
   logic [IDX_W-1:0] gsel;
   logic [6:0]       grp;
   logic [IDX_W-1:0] last_idx;
   logic [23:0]      uspq;
   logic [7:0]       cur_byte;
   logic [31:0]      count_inc;
   logic             div_done;
   logic [25:0]      quotient;

   mtee_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .divisor  (bpm),
      .done     (div_done),
      .quotient (quotient)
   );

   // delta from the stored tick, clamped at zero and at the VLQ capacity
   always_comb begin
      diff      = (event_tick > tick_ff) ? (event_tick - tick_ff) : 32'd0;
      delta_sat = ({3'b000, diff} > CAP) ? CAP[31:0] : diff;
   end

   // VLQ group selection
   always_comb begin
      delta_ext = {3'b000, delta_ff};
      vhi       = '0;
      for (int g = 1; g < VLQ_MAX_BYTES; g++) begin
         if (delta_ext[7*g +: 7] != 7'd0) vhi = IDX_W'(g);
      end
      gsel = vhi - idx_ff;
      grp  = delta_ext[6:0];
      for (int g = 1; g < VLQ_MAX_BYTES; g++) begin
         if (gsel == IDX_W'(g)) grp = delta_ext[7*g +: 7];
      end
   end

   always_comb begin
      uspq     = bpm_zero_ff ? USPQ_DEFAULT : quotient[23:0];
      last_idx = EOT_LAST_IDX;
      cur_byte = BYTE_ZERO;
      case (kind_ff)
         KIND_NOTE: begin
            last_idx = vhi + IDX_W'(3);
            if (idx_ff <= vhi) begin
               cur_byte = {(idx_ff != vhi), grp};
            end else if (idx_ff == vhi + IDX_W'(1)) begin
               cur_byte = STATUS_NOTE_ON;
            end else if (idx_ff == vhi + IDX_W'(2)) begin
               cur_byte = {1'b0, note_ff};
            end else begin
               cur_byte = on_ff ? {1'b0, vel_ff} : BYTE_ZERO;
            end
         end
         KIND_TEMPO: begin
            last_idx = TEMPO_LAST_IDX;
            case (idx_ff)
               3'd0:    cur_byte = BYTE_ZERO;
               3'd1:    cur_byte = META_PREFIX;
               3'd2:    cur_byte = META_TEMPO;
               3'd3:    cur_byte = META_TEMPO_LEN;
               3'd4:    cur_byte = uspq[23:16];
               3'd5:    cur_byte = uspq[15:8];
               default: cur_byte = uspq[7:0];
            endcase
         end
         default: begin
            last_idx = EOT_LAST_IDX;
            case (idx_ff)
               3'd0:    cur_byte = BYTE_ZERO;
               3'd1:    cur_byte = META_PREFIX;
               3'd2:    cur_byte = META_EOT;
               default: cur_byte = BYTE_ZERO;
            endcase
         end
      endcase
   end

   always_comb begin
      count_inc   = count_ff + 32'd1;
      tick_in     = tick_ff;
      count_in    = count_ff;
      delta_in    = delta_ff;
      kind_in     = kind_ff;
      on_in       = on_ff;
      note_in     = note_ff;
      vel_in      = vel_ff;
      bpm_zero_in = bpm_zero_ff;
      idx_in      = idx_ff;
      vld_in      = vld_ff && !rsp_tready;
      byte_in     = byte_ff;
      last_in     = last_ff;
      len_in      = len_ff;
      if (cmd.load) begin
         kind_in     = req_kind;
         on_in       = note_on;
         note_in     = note_number;
         vel_in      = velocity;
         bpm_zero_in = (bpm == 10'd0);
         idx_in      = '0;
         if (req_kind == KIND_NOTE) begin
            delta_in = delta_sat;
            tick_in  = tick_ff + delta_sat;
         end else begin
            delta_in = '0;
         end
      end
      if (cmd.emit) begin
         vld_in   = 1'b1;
         byte_in  = cur_byte;
         last_in  = (idx_ff == last_idx);
         len_in   = count_inc;
         idx_in   = idx_ff + IDX_W'(1);
         count_in = count_inc;
         if (kind_ff == KIND_EOT && idx_ff == last_idx) begin
            count_in = '0;
            tick_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff  <= '0;
         count_ff <= '0;
         vld_ff   <= 1'b0;
         idx_ff   <= '0;
         kind_ff  <= KIND_EOT;
      end else begin
         tick_ff  <= tick_in;
         count_ff <= count_in;
         vld_ff   <= vld_in;
         idx_ff   <= idx_in;
         kind_ff  <= kind_in;
      end
      delta_ff    <= delta_in;
      on_ff       <= on_in;
      note_ff     <= note_in;
      vel_ff      <= vel_in;
      bpm_zero_ff <= bpm_zero_in;
      byte_ff     <= byte_in;
      last_ff     <= last_in;
      len_ff      <= len_in;
   end

   assign stat.out_free = !vld_ff || rsp_tready;
   assign stat.div_done = div_done;
   assign stat.last     = (idx_ff == last_idx);

   assign rsp_tvalid = vld_ff;
   assign rsp_byte   = byte_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_length = len_ff;

`ifndef NO_ASSERTIONS
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!vld_ff || rsp_tready))
      else $error("byte emitted over a pending item");

   a_eot_clear: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && kind_ff == KIND_EOT && idx_ff == last_idx)
      |=> (count_ff == 32'd0 && tick_ff == 32'd0 && last_ff))
      else $error("end of track did not clear state");

   a_len_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && !(kind_ff == KIND_EOT && idx_ff == last_idx))
      |=> (len_ff == count_ff))
      else $error("track length differs from byte count");

   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !cmd.emit)
      else $error("load during emit");
`endif

endmodule

/* rtl/core/mtee_ctrl.sv */
// Controller: sequences accept, tempo divide and byte emission.
module mtee_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic [1:0]         req_kind,
   output logic               req_tready,
   output mtee_pkg::cmd_type  cmd,
   input  mtee_pkg::stat_type stat
);
   import mtee_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               case (req_kind)
                  KIND_NOTE, KIND_EOT: begin
                     cmd.load = 1'b1;
                     state_in = ST_EMIT;
                  end
                  KIND_TEMPO: begin
                     cmd.load      = 1'b1;
                     cmd.div_start = 1'b1;
                     state_in      = ST_DIV;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_DIV: begin
            if (stat.div_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               if (stat.last) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

/* rtl/core/midi_track_event_encoder_top.sv */
// After accept, a note or end of track enters the emit state; a tempo first waits for the divide.
// Bytes leave at one per cycle while the output is taken; the output register holds one byte.
// Note: 4 to VLQ_MAX_BYTES+3 bytes. End of track: 4 bytes. A new item is taken only after the last byte is emitted.
// Tempo: 7 bytes, emitted after the 26-step bit-serial divide for 60000000/bpm.
// Synchronous active-high reset clears tick, byte count, state machine and output valid.
module midi_track_event_encoder_top #(
   parameter int VLQ_MAX_BYTES = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // event_tick[31:0], note_on[32], note_number[39:33], velocity[46:40], bpm[56:47], zeros
   input  logic [63:0] req_tdata,
   // req_type[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_byte[7:0], track_length[39:8]
   output logic [39:0] rsp_tdata,
   output logic        rsp_tlast
);
   import mtee_pkg::*;

   cmd_type     cmd;
   stat_type    stat;
   logic [7:0]  rsp_byte;
   logic [31:0] rsp_length;

   mtee_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser),
      .req_tready (req_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   mtee_dp #(
      .VLQ_MAX_BYTES (VLQ_MAX_BYTES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_kind    (req_tuser),
      .event_tick  (req_tdata[31:0]),
      .note_on     (req_tdata[32]),
      .note_number (req_tdata[39:33]),
      .velocity    (req_tdata[46:40]),
      .bpm         (req_tdata[56:47]),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_byte    (rsp_byte),
      .rsp_tlast   (rsp_tlast),
      .rsp_length  (rsp_length)
   );

   assign rsp_tdata = {rsp_length, rsp_byte};

endmodule

/* test/tb_midi_track_event_encoder_top.sv */
// Testbench for the MIDI track event encoder: random and directed items against a byte predictor.
module tb_midi_track_event_encoder_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mtee_pkg::*;

   localparam int          VLQ_MAX_BYTES  = 4;
   localparam logic [63:0] DELTA_CAP      = (64'd1 << (7 * VLQ_MAX_BYTES)) - 64'd1;
   localparam logic [1:0]  KIND_UNUSED    = 2'd3;
   localparam int          RANDOM_ITEMS   = 280;
   localparam int          HOLD_CYCLES    = 300;
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int          DRAIN_CYCLES   = 40;

   class track_scoreboard;
      typedef struct {
         logic [7:0]  data;
         logic        last;
         logic [31:0] length;
      } track_byte_type;

      track_byte_type expected_track_bytes[$];
      logic [31:0] tick_now;
      logic [31:0] byte_total;
      int          errors;

      function new();
         tick_now   = '0;
         byte_total = '0;
         errors     = 0;
      endfunction

      function void predict_track_bytes(logic [1:0] kind, logic [63:0] data);
         logic [7:0]     seq[$];
         logic [6:0]     grp[8];
         logic [63:0]    delta;
         logic [63:0]    rest;
         logic [31:0]    uspq;
         int             grp_cnt;
         track_byte_type entry;
         case (kind)
            KIND_NOTE: begin
               delta = (data[31:0] > tick_now) ? 64'(data[31:0] - tick_now) : 64'd0;
               if (delta > DELTA_CAP) delta = DELTA_CAP;
               rest    = delta;
               grp[0]  = rest[6:0];
               grp_cnt = 1;
               rest    = rest >> 7;
               while (rest != 0 && grp_cnt < 8) begin
                  grp[grp_cnt] = rest[6:0];
                  grp_cnt++;
                  rest = rest >> 7;
               end
               for (int i = grp_cnt - 1; i >= 0; i--)
                  seq.push_back(((i != 0) ? VLQ_CONT : BYTE_ZERO) | {1'b0, grp[i]});
               seq.push_back(STATUS_NOTE_ON);
               seq.push_back({1'b0, data[39:33]});
               seq.push_back(data[32] ? {1'b0, data[46:40]} : BYTE_ZERO);
               tick_now = tick_now + delta[31:0];
            end
            KIND_TEMPO: begin
               uspq = (data[56:47] == 10'd0) ? 32'(USPQ_DEFAULT)
                                             : 32'(USPQ_NUM) / 32'(data[56:47]);
               seq.push_back(BYTE_ZERO);
               seq.push_back(META_PREFIX);
               seq.push_back(META_TEMPO);
               seq.push_back(META_TEMPO_LEN);
               seq.push_back(uspq[23:16]);
               seq.push_back(uspq[15:8]);
               seq.push_back(uspq[7:0]);
            end
            KIND_EOT: begin
               seq.push_back(BYTE_ZERO);
               seq.push_back(META_PREFIX);
               seq.push_back(META_EOT);
               seq.push_back(BYTE_ZERO);
            end
            default: ;
         endcase
         foreach (seq[i]) begin
            byte_total   = byte_total + 32'd1;
            entry.data   = seq[i];
            entry.last   = (i == seq.size() - 1);
            entry.length = byte_total;
            expected_track_bytes.push_back(entry);
         end
         if (kind == KIND_EOT) begin
            tick_now   = '0;
            byte_total = '0;
         end
      endfunction

      function void check_track_byte(logic [39:0] data, logic last);
         track_byte_type want;
         if (expected_track_bytes.size() == 0) begin
            $display("%0t: unexpected byte: expected none, actual %h length %0d",
                     $time, data[7:0], data[39:8]);
            errors++;
            return;
         end
         want = expected_track_bytes.pop_front();
         if (data[7:0] !== want.data) begin
            $display("%0t: out_byte expected %h actual %h", $time, want.data, data[7:0]);
            errors++;
         end
         if (last !== want.last) begin
            $display("%0t: last_byte expected %b actual %b", $time, want.last, last);
            errors++;
         end
         if (data[39:8] !== want.length) begin
            $display("%0t: track_length expected %0d actual %0d",
                     $time, want.length, data[39:8]);
            errors++;
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;

   int send_idle_pct = 14;
   int recv_idle_pct = 52;
   bit hold_rsp      = 1'b0;

   track_scoreboard sb = new();

   midi_track_event_encoder_top #(
      .VLQ_MAX_BYTES(VLQ_MAX_BYTES)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   always #5 clock = ~clock;

   function automatic logic [63:0] pack_fields(logic [31:0] tick, logic on, logic [6:0] num,
                                               logic [6:0] vel, logic [9:0] bpm);
      return {7'd0, bpm, vel, num, on, tick};
   endfunction

   function automatic logic [63:0] random_fields();
      return pack_fields($urandom, 1'($urandom), 7'($urandom), 7'($urandom), 10'($urandom));
   endfunction

   task automatic put_item(logic [1:0] kind, logic [63:0] data);
      int gap;
      gap = 0;
      while (gap < 30 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= data;
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      sb.predict_track_bytes(kind, data);
      @(posedge clock);
   endtask

   task automatic send_note(logic [31:0] tick, logic on, logic [6:0] num, logic [6:0] vel);
      put_item(KIND_NOTE, pack_fields(tick, on, num, vel, 10'($urandom)));
   endtask

   task automatic send_tempo(logic [9:0] bpm);
      put_item(KIND_TEMPO, pack_fields($urandom, 1'($urandom), 7'($urandom), 7'($urandom), bpm));
   endtask

   // receiver: random backpressure plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      forever begin
         @(negedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_track_byte(rsp_tdata, rsp_tlast);
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(negedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("FAIL midi_track_event_encoder_top");
      $finish;
   end

   initial begin
      int          count;
      int          pick;
      bit          pressure_done;
      logic [31:0] tick;
      logic [31:0] step;
      int          tempo_list[7];
      tempo_list    = '{0, 1, 2, 3, 4, 120, 1023};
      pressure_done = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // delta size boundaries, past and saturating ticks, field extremes
      send_note(32'd0, 1'b1, 7'd0, 7'd0);
      send_note(32'd127, 1'b1, 7'd127, 7'd127);
      send_note(sb.tick_now + 32'd128, 1'b0, 7'd64, 7'd127);
      send_note(sb.tick_now + 32'd16383, 1'b1, 7'd60, 7'd1);
      send_note(sb.tick_now + 32'd16384, 1'b0, 7'd1, 7'd0);
      send_note(sb.tick_now + 32'd2097151, 1'b1, 7'd85, 7'd42);
      send_note(sb.tick_now + 32'd2097152, 1'b1, 7'd42, 7'd85);
      send_note(sb.tick_now + DELTA_CAP[31:0], 1'b1, 7'd127, 7'd126);
      send_note(32'd100, 1'b1, 7'd10, 7'd20);
      send_note(32'hFFFF_FFFF, 1'b1, 7'd127, 7'd127);
      send_note(32'hFFFF_FFFF, 1'b0, 7'd0, 7'd127);
      send_note(sb.tick_now, 1'b1, 7'd99, 7'd64);
      foreach (tempo_list[i]) send_tempo(10'(tempo_list[i]));
      put_item(KIND_UNUSED, random_fields());
      put_item(KIND_EOT, random_fields());
      send_note(32'd5, 1'b1, 7'd70, 7'd100);
      put_item(KIND_UNUSED, random_fields());
      put_item(KIND_EOT, random_fields());

      count = 0;
      while (count < RANDOM_ITEMS) begin
         if (count < RANDOM_ITEMS / 3) begin
            send_idle_pct = 14;
            recv_idle_pct = 52;
         end else if (count < 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 52;
            recv_idle_pct = 14;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (count >= 260 && !pressure_done) begin
            hold_rsp      = 1'b1;
            pressure_done = 1'b1;
         end
         pick = $urandom_range(99);
         if (pick < 62) begin
            case ($urandom_range(4))
               0:       step = $urandom_range(127);
               1:       step = $urandom_range(16383, 128);
               2:       step = $urandom_range(2097151, 16384);
               3:       step = $urandom_range(DELTA_CAP[31:0], 2097152);
               default: step = $urandom_range(3);
            endcase
            if ($urandom_range(19) == 0)
               tick = sb.tick_now + DELTA_CAP[31:0] + 32'd1 + 32'($urandom_range(1000));
            else if ($urandom_range(19) == 0)
               tick = sb.tick_now - 32'($urandom_range(1000));
            else
               tick = sb.tick_now + step;
            send_note(tick, 1'($urandom), 7'($urandom), 7'($urandom));
            count++;
         end else if (pick < 72) begin
            send_note($urandom, 1'($urandom), 7'($urandom), 7'($urandom));
            count++;
         end else if (pick < 84) begin
            send_tempo(($urandom_range(7) == 0) ? 10'($urandom_range(3))
                                                : 10'($urandom_range(1023)));
            count++;
         end else if (pick < 93) begin
            put_item(KIND_EOT, random_fields());
            count++;
         end else begin
            put_item(KIND_UNUSED, random_fields());
         end
      end
      req_tvalid <= 1'b0;

      while (sb.expected_track_bytes.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("PASS midi_track_event_encoder_top");
      else
         $display("FAIL midi_track_event_encoder_top");
      $finish;
   end

endmodule
